### hdl/ccr_pkg.sv
`default_nettype none
package ccr_pkg;

    localparam int SIDE_W   = 13;
    localparam int POS_W    = 12;
    localparam int RAD_W    = 12;
    localparam int CTR_W    = 16;
    localparam int STEP_W   = 13;
    localparam int DEC_W    = 18;
    localparam int COORD_W  = 18;
    localparam int RGBA_W   = 32;
    localparam int IDX_W    = 3;
    localparam int CFG_IDX_W = 2;

    localparam int DEF_MAX_IMAGE_SIDE = 4096;
    localparam int DEF_MAX_RADIUS     = 4095;

    localparam logic [SIDE_W-1:0] RESET_WIDTH  = SIDE_W'(640);
    localparam logic [SIDE_W-1:0] RESET_HEIGHT = SIDE_W'(480);

    localparam int IN_DATA_W  = 80;
    localparam int OUT_DATA_W = 72;

    typedef enum logic {
        CMD_START   = 1'b0,
        CMD_ADVANCE = 1'b1
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH  = 2'd0,
        REG_IMAGE_HEIGHT = 2'd1
    } t_reg_idx;

    typedef enum logic [1:0] {
        JOB_PIXEL = 2'b00,
        JOB_STEP  = 2'b01,
        JOB_END   = 2'b10
    } t_job;

    typedef logic signed [COORD_W-1:0] t_coord;

    typedef struct packed {
        logic   vert;
        t_coord pos;
        t_coord lo;
        t_coord hi;
    } t_seg;

    typedef struct packed {
        logic             visible;
        logic [POS_W-1:0] span_end;
        logic [POS_W-1:0] span_start;
        logic [POS_W-1:0] line_pos;
    } t_clip;

endpackage
`default_nettype wire

### hdl/clipped_circle_rasterizer.sv
`default_nettype none
// Midpoint circle rasterizer with clipping to a configurable image size. A start
// word (tuser 0) latches centre, radius, fill mode and colour and produces no
// segment, except for a zero radius, which gives one pixel at the centre when it
// lies inside the image. Each advance word (tuser 1) runs one step of the circle
// recurrence in the cycle it is accepted and then hands out its segments one per
// cycle while the output is not stalled: eight pixels for an outline or four
// spans for a filled disc; the word that closes the circle gives four axis pixels
// or two diameters. A word with segments therefore occupies the block until its
// last segment is handed out, as a single segment clipper sits behind the step
// logic. The next word is taken in the cycle its predecessor's final segment
// moves into the output register, so the input does not wait for that segment to
// leave the output register. Width and height must be written through the config
// channel while the block is idle; the block itself does not enforce this.
module clipped_circle_rasterizer #(
    parameter int MAX_IMAGE_SIDE = ccr_pkg::DEF_MAX_IMAGE_SIDE,
    parameter int MAX_RADIUS     = ccr_pkg::DEF_MAX_RADIUS
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [ccr_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [ccr_pkg::SIDE_W-1:0]        i_cfg_data,
    input  wire logic                              i_s_axis_tvalid,
    output logic                                   o_s_axis_tready,
    // center_x[15:0], center_y[31:16], radius[43:32], fill_mode[44], rgba[76:45], zero pad
    input  wire logic [ccr_pkg::IN_DATA_W-1:0]     i_s_axis_tdata,
    // cmd[0]
    input  wire logic                              i_s_axis_tuser,
    output logic                                   o_m_axis_tvalid,
    input  wire logic                              i_m_axis_tready,
    // line_pos[11:0], span_start[23:12], span_end[35:24], visible[36],
    // out_rgba[68:37], circle_done[69], zero pad
    output logic [ccr_pkg::OUT_DATA_W-1:0]         o_m_axis_tdata,
    // vertical[0]
    output logic                                   o_m_axis_tuser,
    output logic                                   o_m_axis_tlast
);
    import ccr_pkg::*;

    localparam int LIM_W = 17;

    logic [SIDE_W-1:0]        r_width;
    logic [SIDE_W-1:0]        r_height;
    logic                     r_active;
    logic [STEP_W-1:0]        r_step_x;
    logic [STEP_W-1:0]        r_step_y;
    logic signed [DEC_W-1:0]  r_decision;
    logic signed [CTR_W-1:0]  r_centre_col;
    logic signed [CTR_W-1:0]  r_centre_row;
    logic [RAD_W-1:0]         r_radius;
    logic                     r_fill;
    logic [RGBA_W-1:0]        r_rgba;

    logic                     r_job_valid;
    t_job                     r_job_kind;
    logic [IDX_W-1:0]         r_job_idx;

    logic                     r_out_valid;
    logic [OUT_DATA_W-1:0]    r_out_data;
    logic                     r_out_vert;
    logic                     r_out_last;

    // input word fields
    t_cmd                     in_cmd;
    logic signed [CTR_W-1:0]  in_cx;
    logic signed [CTR_W-1:0]  in_cy;
    logic [RAD_W-1:0]         in_radius;
    logic                     in_fill;
    logic [RGBA_W-1:0]        in_rgba;

    logic                     in_go;
    logic                     out_free;
    logic                     emit;
    logic                     job_fin;
    logic [IDX_W-1:0]         last_idx;

    logic [RAD_W-1:0]         n_radius;
    logic                     n_job_start;
    t_job                     n_job_kind;
    logic signed [DEC_W-1:0]  n_decision;
    logic [STEP_W-1:0]        n_step_y;
    logic                     centre_in;

    t_coord                   p;
    t_coord                   q;
    t_coord                   ax;
    t_coord                   by;
    t_coord                   rr;
    t_seg                     seg;
    t_clip                    clip;
    logic                     seg_done;

    function automatic logic [SIDE_W-1:0] clamp_side(input logic [SIDE_W-1:0] v);
        logic [SIDE_W-1:0] res;
        if (v == '0) begin
            res = SIDE_W'(1);
        end else if ({{(LIM_W-SIDE_W){1'b0}}, v} > LIM_W'(MAX_IMAGE_SIDE)) begin
            res = SIDE_W'(MAX_IMAGE_SIDE);
        end else begin
            res = v;
        end
        return res;
    endfunction

    assign in_cmd    = t_cmd'(i_s_axis_tuser);
    assign in_cx     = i_s_axis_tdata[15:0];
    assign in_cy     = i_s_axis_tdata[31:16];
    assign in_radius = i_s_axis_tdata[43:32];
    assign in_fill   = i_s_axis_tdata[44];
    assign in_rgba   = i_s_axis_tdata[76:45];

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= RESET_WIDTH;
            r_height <= RESET_HEIGHT;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_IMAGE_WIDTH:  r_width  <= clamp_side(i_cfg_data);
                REG_IMAGE_HEIGHT: r_height <= clamp_side(i_cfg_data);
                default: ;
            endcase
        end
    end

    // handshake
    always_comb begin
        unique case (r_job_kind)
            JOB_PIXEL: last_idx = IDX_W'(0);
            JOB_END:   last_idx = r_fill ? IDX_W'(1) : IDX_W'(3);
            JOB_STEP:  last_idx = r_fill ? IDX_W'(3) : IDX_W'(7);
            default:   last_idx = IDX_W'(0);
        endcase
        out_free        = !r_out_valid || i_m_axis_tready;
        emit            = r_job_valid && out_free;
        job_fin         = emit && (r_job_idx == last_idx);
        o_s_axis_tready = !r_job_valid || job_fin;
        in_go           = i_s_axis_tvalid && o_s_axis_tready;
    end

    // step logic
    always_comb begin
        if ({{(LIM_W-RAD_W){1'b0}}, in_radius} > LIM_W'(MAX_RADIUS)) begin
            n_radius = RAD_W'(MAX_RADIUS);
        end else begin
            n_radius = in_radius;
        end
        centre_in = (in_cx >= 0) && (in_cy >= 0) &&
                    (t_coord'(in_cx) < t_coord'({1'b0, r_width})) &&
                    (t_coord'(in_cy) < t_coord'({1'b0, r_height}));
        if (r_decision <= 0) begin
            n_decision = r_decision + DEC_W'({r_step_x, 2'b00}) + DEC_W'(6);
            n_step_y   = r_step_y;
        end else begin
            n_decision = r_decision + DEC_W'({r_step_x, 2'b00})
                         - DEC_W'({r_step_y, 2'b00}) + DEC_W'(10);
            n_step_y   = r_step_y - STEP_W'(1);
        end
        n_job_start = 1'b0;
        n_job_kind  = JOB_STEP;
        if (in_cmd == CMD_START) begin
            n_job_kind  = JOB_PIXEL;
            n_job_start = (n_radius == '0) && centre_in;
        end else if (r_active) begin
            n_job_start = 1'b1;
            n_job_kind  = (r_step_x > r_step_y) ? JOB_END : JOB_STEP;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active     <= 1'b0;
            r_step_x     <= '0;
            r_step_y     <= '0;
            r_decision   <= '0;
            r_centre_col <= '0;
            r_centre_row <= '0;
            r_radius     <= '0;
            r_fill       <= 1'b0;
            r_rgba       <= '0;
        end else if (in_go) begin
            if (in_cmd == CMD_START) begin
                r_centre_col <= in_cx;
                r_centre_row <= in_cy;
                r_radius     <= n_radius;
                r_fill       <= in_fill;
                r_rgba       <= in_rgba;
                r_step_x     <= '0;
                r_step_y     <= STEP_W'(n_radius);
                r_decision   <= DEC_W'(3) - DEC_W'({n_radius, 1'b0});
                r_active     <= (n_radius != '0);
            end else if (r_active) begin
                if (r_step_x > r_step_y) begin
                    r_active <= 1'b0;
                end else begin
                    r_decision <= n_decision;
                    r_step_y   <= n_step_y;
                    r_step_x   <= r_step_x + STEP_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_job_valid <= 1'b0;
            r_job_kind  <= JOB_PIXEL;
            r_job_idx   <= '0;
        end else if (in_go && n_job_start) begin
            r_job_valid <= 1'b1;
            r_job_kind  <= n_job_kind;
            r_job_idx   <= '0;
        end else if (job_fin) begin
            r_job_valid <= 1'b0;
        end else if (emit) begin
            r_job_idx <= r_job_idx + IDX_W'(1);
        end
    end

    // segment select
    always_comb begin
        p  = t_coord'(r_centre_col);
        q  = t_coord'(r_centre_row);
        ax = t_coord'({1'b0, r_step_x});
        by = t_coord'({1'b0, r_step_y});
        rr = t_coord'({1'b0, r_radius});
        seg.vert = 1'b0;
        seg.pos  = q;
        seg.lo   = p;
        seg.hi   = p;
        unique case (r_job_kind)
            JOB_PIXEL: ;
            JOB_END: begin
                if (r_fill) begin
                    if (r_job_idx == IDX_W'(0)) begin
                        seg.lo = p - rr;
                        seg.hi = p + rr;
                    end else begin
                        seg.vert = 1'b1;
                        seg.pos  = p;
                        seg.lo   = q - rr;
                        seg.hi   = q + rr;
                    end
                end else begin
                    case (r_job_idx)
                        IDX_W'(0): begin seg.lo = p + rr; seg.hi = p + rr; end
                        IDX_W'(1): begin seg.lo = p - rr; seg.hi = p - rr; end
                        IDX_W'(2): seg.pos = q + rr;
                        default:   seg.pos = q - rr;
                    endcase
                end
            end
            JOB_STEP: begin
                if (r_fill) begin
                    case (r_job_idx)
                        IDX_W'(0): begin seg.pos = q + by; seg.lo = p - ax; seg.hi = p + ax; end
                        IDX_W'(1): begin seg.pos = q + ax; seg.lo = p - by; seg.hi = p + by; end
                        IDX_W'(2): begin seg.pos = q - by; seg.lo = p - ax; seg.hi = p + ax; end
                        default:   begin seg.pos = q - ax; seg.lo = p - by; seg.hi = p + by; end
                    endcase
                end else begin
                    case (r_job_idx)
                        IDX_W'(0): begin seg.pos = q + by; seg.lo = p + ax; end
                        IDX_W'(1): begin seg.pos = q + ax; seg.lo = p + by; end
                        IDX_W'(2): begin seg.pos = q + ax; seg.lo = p - by; end
                        IDX_W'(3): begin seg.pos = q + by; seg.lo = p - ax; end
                        IDX_W'(4): begin seg.pos = q - by; seg.lo = p - ax; end
                        IDX_W'(5): begin seg.pos = q - ax; seg.lo = p - by; end
                        IDX_W'(6): begin seg.pos = q - ax; seg.lo = p + by; end
                        default:   begin seg.pos = q - by; seg.lo = p + ax; end
                    endcase
                    seg.hi = seg.lo;
                end
            end
            default: ;
        endcase
        seg_done = (r_job_idx == last_idx) && (r_job_kind != JOB_STEP);
    end

    ccr_clip u_clip (
        .i_seg    (seg),
        .i_width  (r_width),
        .i_height (r_height),
        .o_clip   (clip)
    );

    // output word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_data <= {2'b00, seg_done, r_rgba, clip.visible, clip.span_end,
                           clip.span_start, clip.line_pos};
            r_out_vert <= seg.vert;
            r_out_last <= (r_job_idx == last_idx);
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_vert;
    assign o_m_axis_tlast  = r_out_last;

endmodule
`default_nettype wire

### hdl/ccr_clip.sv
`default_nettype none
module ccr_clip (
    input  wire ccr_pkg::t_seg                    i_seg,
    input  wire logic [ccr_pkg::SIDE_W-1:0]       i_width,
    input  wire logic [ccr_pkg::SIDE_W-1:0]       i_height,
    output ccr_pkg::t_clip                        o_clip
);
    import ccr_pkg::*;

    logic [SIDE_W-1:0] along;
    logic [SIDE_W-1:0] across;
    t_coord            along_s;
    t_coord            across_s;
    t_coord            along_max;
    t_coord            lo_c;
    t_coord            hi_c;
    logic              vis;

    always_comb begin
        along     = i_seg.vert ? i_height : i_width;
        across    = i_seg.vert ? i_width : i_height;
        along_s   = t_coord'({1'b0, along});
        across_s  = t_coord'({1'b0, across});
        along_max = along_s - t_coord'(1);
        vis = (i_seg.pos >= 0) && (i_seg.pos < across_s) &&
              (i_seg.hi >= 0) && (i_seg.lo < along_s);
        lo_c = (i_seg.lo < 0) ? t_coord'(0) : i_seg.lo;
        hi_c = (i_seg.hi > along_max) ? along_max : i_seg.hi;
        o_clip.visible    = vis;
        o_clip.line_pos   = vis ? i_seg.pos[POS_W-1:0] : '0;
        o_clip.span_start = vis ? lo_c[POS_W-1:0] : '0;
        o_clip.span_end   = vis ? hi_c[POS_W-1:0] : '0;
    end

endmodule
`default_nettype wire

### tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import ccr_pkg::*;

    localparam int LIMIT_CYCLES = 400000;
    localparam int SETTLE_CYCLES = 24;
    localparam int HOLD_CYCLES = 300;
    localparam int RANDOM_WORDS = 260;

    typedef struct {
        logic             vertical;
        logic [POS_W-1:0] line_pos;
        logic [POS_W-1:0] span_start;
        logic [POS_W-1:0] span_end;
        logic             visible;
        logic [31:0]      rgba;
        logic             last;
        logic             done;
    } seg_word_t;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [SIDE_W-1:0]     i_cfg_data = '0;
    logic                  i_s_axis_tvalid = 1'b0;
    logic                  o_s_axis_tready;
    logic [IN_DATA_W-1:0]  i_s_axis_tdata = '0;
    logic                  i_s_axis_tuser = 1'b0;
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] o_m_axis_tdata;
    logic                  o_m_axis_tuser;
    logic                  o_m_axis_tlast;

    clipped_circle_rasterizer i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    // rasterizer state as the testbench sees it
    longint    img_w = 640;
    longint    img_h = 480;
    bit        ras_active;
    longint    ras_x, ras_y, ras_dec, ras_col, ras_row, ras_rad;
    bit        ras_fill;
    logic [31:0] ras_rgba;

    seg_word_t pending_segs[$];
    int        errors;
    int        segs_checked;
    int        words_used;
    int        circles_closed;
    int        size_settings;
    int        cycles;
    bit        idle_en;
    int        hold_requests;
    int        hold_seen;
    int        hold_left;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= LIMIT_CYCLES) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic seg_word_t clip_seg(bit vert, longint pos, longint lo, longint hi);
        seg_word_t s;
        longint along;
        longint across;
        longint t;
        bit vis;
        along = vert ? img_h : img_w;
        across = vert ? img_w : img_h;
        if (lo > hi) begin
            t = lo;
            lo = hi;
            hi = t;
        end
        vis = pos >= 0 && pos < across && hi >= 0 && lo < along;
        if (vis) begin
            if (lo < 0) lo = 0;
            if (hi > along - 1) hi = along - 1;
        end else begin
            pos = 0;
            lo = 0;
            hi = 0;
        end
        s.vertical = vert;
        s.line_pos = pos[POS_W-1:0];
        s.span_start = lo[POS_W-1:0];
        s.span_end = hi[POS_W-1:0];
        s.visible = vis;
        s.rgba = ras_rgba;
        s.last = 1'b0;
        s.done = 1'b0;
        return s;
    endfunction

    function automatic seg_word_t pixel(longint col, longint row);
        return clip_seg(1'b0, row, col, col);
    endfunction

    function automatic void rasterize_word(t_cmd cmd, logic [15:0] cx, logic [15:0] cy,
                                           logic [11:0] r, logic fill, logic [31:0] rgba);
        seg_word_t batch[$];
        longint p, q, x, y, rad;
        bit closing;
        closing = 1'b0;
        if (cmd == CMD_START) begin
            ras_col = longint'($signed(cx));
            ras_row = longint'($signed(cy));
            ras_rad = longint'(r);
            ras_fill = fill;
            ras_rgba = rgba;
            ras_x = 0;
            ras_y = ras_rad;
            ras_dec = 3 - 2 * ras_rad;
            ras_active = 1'b1;
            if (ras_rad == 0) begin
                ras_active = 1'b0;
                if (ras_col >= 0 && ras_col < img_w && ras_row >= 0 && ras_row < img_h) begin
                    batch.push_back(pixel(ras_col, ras_row));
                    closing = 1'b1;
                end
            end
        end else if (ras_active) begin
            p = ras_col;
            q = ras_row;
            rad = ras_rad;
            if (ras_x > ras_y) begin
                if (ras_fill) begin
                    batch.push_back(clip_seg(1'b0, q, p - rad, p + rad));
                    batch.push_back(clip_seg(1'b1, p, q - rad, q + rad));
                end else begin
                    batch.push_back(pixel(p + rad, q));
                    batch.push_back(pixel(p - rad, q));
                    batch.push_back(pixel(p, q + rad));
                    batch.push_back(pixel(p, q - rad));
                end
                ras_active = 1'b0;
                closing = 1'b1;
            end else begin
                if (ras_dec <= 0) begin
                    ras_dec += 4 * ras_x + 6;
                end else begin
                    ras_dec += 4 * (ras_x - ras_y) + 10;
                    ras_y -= 1;
                end
                ras_x += 1;
                x = ras_x;
                y = ras_y;
                if (ras_fill) begin
                    batch.push_back(clip_seg(1'b0, q + y, p - x, p + x));
                    batch.push_back(clip_seg(1'b0, q + x, p - y, p + y));
                    batch.push_back(clip_seg(1'b0, q - y, p - x, p + x));
                    batch.push_back(clip_seg(1'b0, q - x, p - y, p + y));
                end else begin
                    batch.push_back(pixel(p + x, q + y));
                    batch.push_back(pixel(p + y, q + x));
                    batch.push_back(pixel(p - y, q + x));
                    batch.push_back(pixel(p - x, q + y));
                    batch.push_back(pixel(p - x, q - y));
                    batch.push_back(pixel(p - y, q - x));
                    batch.push_back(pixel(p + y, q - x));
                    batch.push_back(pixel(p + x, q - y));
                end
            end
        end
        if (batch.size() > 0) begin
            batch[batch.size()-1].last = 1'b1;
            batch[batch.size()-1].done = closing;
        end
        if (closing) circles_closed++;
        foreach (batch[i]) pending_segs.push_back(batch[i]);
    endfunction

    task automatic send_word(t_cmd cmd, logic [15:0] cx, logic [15:0] cy, logic [11:0] r,
                             logic fill, logic [31:0] rgba);
        while (idle_en && $urandom_range(99) < 22) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser <= cmd;
        i_s_axis_tdata <= {3'b000, rgba, fill, r, cy, cx};
        do @(posedge i_clk); while (!o_s_axis_tready);
        if (cmd == CMD_START || ras_active) words_used++;
        rasterize_word(cmd, cx, cy, r, fill, rgba);
    endtask

    task automatic stop_sending();
        i_s_axis_tvalid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_segs.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(t_reg_idx idx, logic [SIDE_W-1:0] value);
        longint side;
        side = longint'(value);
        if (side < 1) side = 1;
        if (side > DEF_MAX_IMAGE_SIDE) side = DEF_MAX_IMAGE_SIDE;
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == REG_IMAGE_WIDTH) img_w = side;
        else img_h = side;
        size_settings++;
    endtask

    task automatic set_image(logic [SIDE_W-1:0] w, logic [SIDE_W-1:0] h);
        stop_sending();
        wait_drained();
        cfg_write(REG_IMAGE_WIDTH, w);
        cfg_write(REG_IMAGE_HEIGHT, h);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic send_advance();
        send_word(CMD_ADVANCE, 16'($urandom), 16'($urandom), 12'($urandom), 1'($urandom),
                  $urandom);
    endtask

    task automatic advance_circle(int max_adv);
        int k;
        k = 0;
        while (ras_active && k < max_adv) begin
            send_advance();
            k++;
        end
    endtask

    task automatic run_circle(logic [15:0] cx, logic [15:0] cy, logic [11:0] r, logic fill,
                              logic [31:0] rgba, int max_adv);
        send_word(CMD_START, cx, cy, r, fill, rgba);
        advance_circle(max_adv);
    endtask

    task automatic random_circle();
        int sel;
        int rad;
        int cx, cy;
        int max_adv;
        sel = $urandom_range(99);
        if (sel < 8) rad = 0;
        else if (sel < 85) rad = $urandom_range(24, 1);
        else if (sel < 95) rad = $urandom_range(120, 25);
        else rad = $urandom_range(4095);
        if ($urandom_range(99) < 85) begin
            cx = int'($urandom_range(int'(img_w) + 2 * rad + 16)) - rad - 8;
            cy = int'($urandom_range(int'(img_h) + 2 * rad + 16)) - rad - 8;
        end else begin
            cx = $urandom_range(65535);
            cy = $urandom_range(65535);
        end
        if (rad > 120) max_adv = $urandom_range(6);
        else if ($urandom_range(99) < 10) max_adv = $urandom_range(rad);
        else max_adv = 1 << 20;
        run_circle(16'(cx), 16'(cy), 12'(rad), 1'($urandom), $urandom, max_adv);
        // stray advance, on an idle rasterizer unless the advance limit cut the circle short
        if ($urandom_range(99) < 5) send_advance();
    endtask

    always @(posedge i_clk) begin
        if (hold_requests != hold_seen) begin
            hold_seen <= hold_requests;
            hold_left <= HOLD_CYCLES;
            i_m_axis_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_m_axis_tready <= 1'b0;
        end else if (idle_en) begin
            i_m_axis_tready <= ($urandom_range(99) >= 22);
        end else begin
            i_m_axis_tready <= 1'b1;
        end
    end

    function automatic void check_field(string name, longint want, longint got);
        if (want != got) begin
            errors++;
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
        end
    endfunction

    always @(posedge i_clk) begin : check_out
        seg_word_t want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (pending_segs.size() == 0) begin
                errors++;
                $error("segment word with nothing expected: tdata 0x%0h", o_m_axis_tdata);
            end else begin
                want = pending_segs.pop_front();
                segs_checked++;
                check_field("vertical", want.vertical, o_m_axis_tuser);
                check_field("line_pos", want.line_pos, o_m_axis_tdata[11:0]);
                check_field("span_start", want.span_start, o_m_axis_tdata[23:12]);
                check_field("span_end", want.span_end, o_m_axis_tdata[35:24]);
                check_field("visible", want.visible, o_m_axis_tdata[36]);
                check_field("out_rgba", want.rgba, o_m_axis_tdata[68:37]);
                check_field("last", want.last, o_m_axis_tlast);
                check_field("circle_done", want.done, o_m_axis_tdata[69]);
            end
        end
    end

    task automatic test_single_pixels();
        send_word(CMD_START, 16'd0, 16'd0, 12'd0, 1'b0, 32'h0000_0000);
        send_word(CMD_START, 16'd639, 16'd479, 12'd0, 1'b1, 32'hFFFF_FFFF);
        send_word(CMD_START, 16'd640, 16'd10, 12'd0, 1'b0, 32'hA5A5_5A5A);
        send_word(CMD_START, 16'd10, 16'd480, 12'd0, 1'b0, 32'h5A5A_A5A5);
        send_word(CMD_START, 16'hFFFF, 16'hFFFF, 12'd0, 1'b1, 32'h0F0F_F0F0);
        send_word(CMD_START, 16'h8000, 16'h7FFF, 12'd0, 1'b0, 32'hF0F0_0F0F);
        send_word(CMD_ADVANCE, 16'hFFFF, 16'hFFFF, 12'hFFF, 1'b1, 32'hFFFF_FFFF);
        stop_sending();
        wait_drained();
    endtask

    task automatic test_small_circles();
        run_circle(16'd100, 16'd100, 12'd3, 1'b0, 32'h1234_5678, 1 << 20);
        run_circle(16'd1, 16'd1, 12'd2, 1'b1, 32'h0000_0000, 1 << 20);
        run_circle(16'd637, 16'd478, 12'd4, 1'b0, 32'hFFFF_FFFF, 1 << 20);
        // a huge circle replaced by a new start
        run_circle(16'h7FFF, 16'h8000, 12'd4095, 1'b1, 32'hDEAD_BEEF, 2);
        run_circle(16'd320, 16'hFFFF, 12'd1, 1'b1, 32'h8000_0001, 1 << 20);
        stop_sending();
        wait_drained();
    endtask

    task automatic test_image_sizes();
        logic [SIDE_W-1:0] widths[5];
        logic [SIDE_W-1:0] heights[5];
        widths = '{13'd0, 13'd8191, 13'd4096, 13'd1, 13'($urandom_range(8191))};
        heights = '{13'd0, 13'd8191, 13'd1, 13'd4096, 13'($urandom_range(8191))};
        for (int i = 0; i < 5; i++) begin
            set_image(widths[i], heights[i]);
            repeat (2) random_circle();
        end
        // size change while a circle is half drawn
        set_image(13'd64, 13'd64);
        run_circle(16'd60, 16'd30, 12'd20, 1'b0, 32'hC0FF_EE00, 5);
        set_image(13'd40, 13'd50);
        advance_circle(1 << 20);
        stop_sending();
        wait_drained();
    endtask

    task automatic test_backpressure();
        set_image(13'd640, 13'd480);
        hold_requests++;
        run_circle(16'd320, 16'd240, 12'd30, 1'b1, 32'h7777_8888, 1 << 20);
        run_circle(16'd10, 16'd470, 12'd12, 1'b0, 32'h1111_2222, 1 << 20);
        stop_sending();
        wait_drained();
    endtask

    task automatic test_random_stream();
        int goal;
        int phase;
        goal = words_used + RANDOM_WORDS;
        phase = 0;
        while (words_used < goal) begin
            idle_en = !(words_used > goal - RANDOM_WORDS + 80 &&
                        words_used < goal - RANDOM_WORDS + 200);
            if (words_used >= goal - RANDOM_WORDS + 90 * (phase + 1)) begin
                phase++;
                set_image(13'($urandom_range(8191)), 13'($urandom_range(8191)));
                if ($urandom_range(1)) set_image(13'($urandom_range(700, 1)),
                                                 13'($urandom_range(500, 1)));
            end
            random_circle();
        end
        idle_en = 1'b1;
        stop_sending();
    endtask

    initial begin
        idle_en = 1'b1;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_single_pixels();
        test_small_circles();
        test_image_sizes();
        test_backpressure();
        test_random_stream();
        while (pending_segs.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        $display("covered %0d input words and %0d closed circles, %0d segments checked",
                 words_used, circles_closed, segs_checked);
        $display("image size writes: %0d, clamped extremes and a mid-circle change included",
                 size_settings);
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
